>>> src/sbmd_pkg.sv
// Package for the single-button mode dimmer.
// Holds register indexes, reset values and the config/result structs.
// No dependencies.
`default_nettype none

package sbmd_pkg;

  localparam int unsigned TimeBitsDef = 32;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned ElapsedW    = 32;
  localparam int unsigned InDataW     = 8;
  localparam int unsigned OutDataW    = 48;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTickStep    = 3'd0,
    CfgDebounce    = 3'd1,
    CfgLongPress   = 3'd2,
    CfgBlinkWindow = 3'd3,
    CfgMinLevel    = 3'd4,
    CfgMaxLevel    = 3'd5,
    CfgModeCount   = 3'd6,
    CfgStartLevel  = 3'd7
  } cfg_idx_e;

  localparam logic [9:0]  TickStepRst    = 10'd32;
  localparam logic [15:0] DebounceRst    = 16'd100;
  localparam logic [15:0] LongPressRst   = 16'd3000;
  localparam logic [15:0] BlinkWindowRst = 16'd50;
  localparam logic [7:0]  MinLevelRst    = 8'd30;
  localparam logic [7:0]  MaxLevelRst    = 8'd127;
  localparam logic [3:0]  ModeCountRst   = 4'd5;
  localparam logic [7:0]  StartLevelRst  = 8'd64;

  typedef struct packed {
    logic [9:0]  tick_step_ms;
    logic [15:0] debounce_ms;
    logic [15:0] long_press_ms;
    logic [15:0] blink_window_ms;
    logic [7:0]  min_level;
    logic [7:0]  max_level;
    logic [3:0]  mode_count;
  } cfg_t;

  typedef struct packed {
    logic                save_level;
    logic                save_mode;
    logic                blank_panel;
    logic [ElapsedW-1:0] mode_elapsed_ms;
    logic [7:0]          level;
    logic [2:0]          mode_index;
  } res_t;

endpackage

`default_nettype wire

>>> src/sbmd_core.sv
// Tick logic of the single-button mode dimmer: clock, debounce, press
// timing, mode stepping and brightness ramp. Uses sbmd_pkg.
`default_nettype none

module sbmd_core #(
  parameter int unsigned TIME_BITS = sbmd_pkg::TimeBitsDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          tick_i,
  input  wire logic          button_down_i,
  input  wire sbmd_pkg::cfg_t cfg_i,
  output sbmd_pkg::res_t     res_o
);
  import sbmd_pkg::*;

  localparam int unsigned CmpW = (TIME_BITS > 17) ? TIME_BITS : 17;
  localparam int unsigned ExtW = (TIME_BITS > ElapsedW) ? TIME_BITS : ElapsedW;

  logic [TIME_BITS-1:0] clock_q, clock_d;
  logic [TIME_BITS-1:0] last_change_q, last_change_d;
  logic [TIME_BITS-1:0] last_press_q, last_press_d;
  logic [TIME_BITS-1:0] mode_start_q, mode_start_d;
  logic                 acc_q, acc_d;
  logic [2:0]           mode_q, mode_d;
  logic [7:0]           level_q, level_d;
  logic                 ramp_up_q, ramp_up_d;

  logic [TIME_BITS-1:0] since_press;
  logic [TIME_BITS-1:0] since_change;
  logic [TIME_BITS-1:0] elapsed;
  logic [16:0]          blink_lim;
  logic [3:0]           mode_inc;
  logic [7:0]           level_step;
  logic                 change;
  logic                 ramping;
  logic                 reverse;
  logic                 blank;
  logic                 save_mode;
  logic                 save_level;

  always_comb begin
    clock_d       = clock_q + TIME_BITS'(cfg_i.tick_step_ms);
    since_press   = clock_d - last_press_q;
    since_change  = clock_d - last_change_q;
    blink_lim     = {1'b0, cfg_i.long_press_ms} + {1'b0, cfg_i.blink_window_ms};
    mode_inc      = {1'b0, mode_q} + 4'd1;
    change        = (button_down_i != acc_q) &&
                    (CmpW'(since_change) > CmpW'(cfg_i.debounce_ms));

    last_change_d = last_change_q;
    last_press_d  = last_press_q;
    mode_start_d  = mode_start_q;
    acc_d         = acc_q;
    mode_d        = mode_q;
    level_d       = level_q;
    ramp_up_d     = ramp_up_q;
    blank         = 1'b0;
    save_mode     = 1'b0;
    save_level    = 1'b0;

    if (change) begin
      last_change_d = clock_d;
      acc_d         = button_down_i;
      if (button_down_i) begin
        last_press_d = clock_d;
      end else if (CmpW'(since_press) < CmpW'(cfg_i.long_press_ms)) begin
        mode_d       = (mode_inc >= cfg_i.mode_count) ? 3'd0 : mode_inc[2:0];
        mode_start_d = clock_d;
        blank        = 1'b1;
        save_mode    = 1'b1;
      end else begin
        save_level = 1'b1;
      end
    end

    ramping    = acc_d && (CmpW'(since_press) > CmpW'(cfg_i.long_press_ms));
    level_step = ramp_up_q ? level_q + 8'd1 : level_q - 8'd1;
    reverse    = (level_step <= cfg_i.min_level) || (level_step >= cfg_i.max_level);
    if (ramping) begin
      level_d = level_step;
      if (CmpW'(since_press) <= CmpW'(blink_lim)) begin
        blank = 1'b1;
      end
      if (reverse) begin
        ramp_up_d = ~ramp_up_q;
        blank     = 1'b1;
      end
    end

    elapsed                = clock_d - mode_start_d;
    res_o.mode_index       = mode_d;
    res_o.level            = level_d;
    res_o.mode_elapsed_ms  = ElapsedW'(ExtW'(elapsed));
    res_o.blank_panel      = blank;
    res_o.save_mode        = save_mode;
    res_o.save_level       = save_level;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q       <= '0;
      last_change_q <= '0;
      last_press_q  <= '0;
      mode_start_q  <= '0;
      acc_q         <= 1'b0;
      mode_q        <= '0;
      level_q       <= StartLevelRst;
      ramp_up_q     <= 1'b0;
    end else if (tick_i) begin
      clock_q       <= clock_d;
      last_change_q <= last_change_d;
      last_press_q  <= last_press_d;
      mode_start_q  <= mode_start_d;
      acc_q         <= acc_d;
      mode_q        <= mode_d;
      level_q       <= level_d;
      ramp_up_q     <= ramp_up_d;
    end
  end

endmodule

`default_nettype wire

>>> src/single_button_mode_dimmer.sv
// Single-button mode dimmer: one frame tick in, one result out.
// The result is registered and valid in the cycle after the tick transfer.
// Throughput: one tick per cycle unless m_axis_tready stalls a full output register; it refills in the cycle it drains.
// The whole tick update is one pass of sbmd_core logic into the output register.
// Reset: clock and timestamps zero, button released, mode 0, level 64, ramping down,
// configuration back to its defaults; start_level writes are taken and dropped.
`default_nettype none

module single_button_mode_dimmer #(
  parameter int unsigned TIME_BITS = sbmd_pkg::TimeBitsDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [sbmd_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [sbmd_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  // [0] button_down, [7:1] zero
  input  wire logic [sbmd_pkg::InDataW-1:0]    s_axis_tdata,
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [2:0] mode_index, [10:3] level, [42:11] mode_elapsed_ms, [43] blank_panel,
  // [44] save_mode, [45] save_level, [47:46] zero
  output      logic [sbmd_pkg::OutDataW-1:0]   m_axis_tdata
);
  import sbmd_pkg::*;

  cfg_t cfg_q;
  res_t res;
  res_t res_q;
  logic out_valid_q;
  logic tick;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign tick          = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - $bits(res_t)){1'b0}}, res_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tick_step_ms    <= TickStepRst;
      cfg_q.debounce_ms     <= DebounceRst;
      cfg_q.long_press_ms   <= LongPressRst;
      cfg_q.blink_window_ms <= BlinkWindowRst;
      cfg_q.min_level       <= MinLevelRst;
      cfg_q.max_level       <= MaxLevelRst;
      cfg_q.mode_count      <= ModeCountRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgTickStep:    cfg_q.tick_step_ms    <= cfg_data_i[9:0];
        CfgDebounce:    cfg_q.debounce_ms     <= cfg_data_i;
        CfgLongPress:   cfg_q.long_press_ms   <= cfg_data_i;
        CfgBlinkWindow: cfg_q.blink_window_ms <= cfg_data_i;
        CfgMinLevel:    cfg_q.min_level       <= cfg_data_i[7:0];
        CfgMaxLevel:    cfg_q.max_level       <= cfg_data_i[7:0];
        CfgModeCount:   cfg_q.mode_count      <= cfg_data_i[3:0];
        CfgStartLevel:  ;
        default:        ;
      endcase
    end
  end

  sbmd_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_i        (tick),
    .button_down_i (s_axis_tdata[0]),
    .cfg_i         (cfg_q),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick) begin
      res_q <= res;
    end
  end

  property p_tick_gives_result;
    @(posedge clk_i) disable iff (!rst_ni) tick |=> m_axis_tvalid;
  endproperty
  a_tick_gives_result : assert property (p_tick_gives_result)
    else $error("tick transfer produced no result");

  property p_single_save;
    @(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid |-> !(res_q.save_mode && res_q.save_level);
  endproperty
  a_single_save : assert property (p_single_save)
    else $error("mode and level saves requested together");

  property p_save_mode_blanks;
    @(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid && res_q.save_mode) |-> res_q.blank_panel;
  endproperty
  a_save_mode_blanks : assert property (p_save_mode_blanks)
    else $error("mode change without panel blank");

endmodule

`default_nettype wire
